### rtl/core/fcc_pkg.sv
// Shared types, constants and the control store of the FCC ball point enumerator.
// Used by every module of the block; it depends on nothing else.
package fcc_pkg;

    // Widths fixed by the register and the coordinate fields.
    localparam int unsigned RAD_W      = 14;
    localparam int unsigned ROOT_W     = RAD_W / 2;
    localparam int unsigned COORD_W    = 8;
    localparam int unsigned RAD_MAX    = (1 << RAD_W) - 1;
    localparam int unsigned RADIUS_RST = 2;

    // Default saturation level of the squared radius.
    localparam int unsigned MAX_RADIUS_SQ_DEF = 16383;

    // Program counter of the sequencer.
    localparam int unsigned PC_W = 5;
    typedef logic [PC_W-1:0] t_pc;

    // Datapath operations, one per control word.
    typedef enum logic [4:0] {
        OP_NOP,
        OP_ACCEPT,
        OP_SQRT_EFF,
        OP_SET_XFIRST,
        OP_SQ_X,
        OP_SQRT_REM,
        OP_SET_YFIRST,
        OP_SQ_Y,
        OP_SQRT_COL,
        OP_SET_Z,
        OP_CLR_LAST,
        OP_INC_Y,
        OP_INC_X,
        OP_SET_LAST,
        OP_EMIT,
        OP_INC_Z,
        OP_DELIVER
    } t_op;

    // Jump conditions, one per control word.
    typedef enum logic [3:0] {
        C_NONE,
        C_ALWAYS,
        C_NO_IN,
        C_NOT_FRESH,
        C_SQRT_BUSY,
        C_Y_GT_YL,
        C_COL_EMPTY,
        C_LOADING,
        C_X_AT_LIM,
        C_Z_NOT_FITS,
        C_OUT_BUSY
    } t_cond;

    typedef struct packed {
        t_op   op;
        t_cond cond;
        t_pc   target;
    } t_uword;

    // Flags the datapath reports to the sequencer.
    typedef struct packed {
        logic in_valid;
        logic fresh;
        logic sqrt_busy;
        logic y_gt_yl;
        logic col_empty;
        logic loading;
        logic x_at_lim;
        logic z_fits;
        logic out_busy;
    } t_status;

    // Entry points of the program.
    localparam t_pc S_IDLE       = t_pc'(0);
    localparam t_pc S_WAIT_ROOT  = t_pc'(3);
    localparam t_pc S_SLICE      = t_pc'(5);
    localparam t_pc S_WAIT_REM   = t_pc'(7);
    localparam t_pc S_TRY        = t_pc'(9);
    localparam t_pc S_WAIT_COL   = t_pc'(11);
    localparam t_pc S_NEXT_COL   = t_pc'(15);
    localparam t_pc S_NEXT_SLICE = t_pc'(16);
    localparam t_pc S_EXHAUST    = t_pc'(18);
    localparam t_pc S_EMIT       = t_pc'(19);
    localparam t_pc S_DELIVER    = t_pc'(21);

    // The control store: one word per step.
    function automatic t_uword ucode(input t_pc pc);
        t_uword w;
        w = '{op: OP_NOP, cond: C_ALWAYS, target: S_IDLE};
        case (pc)
            5'd0:  w = '{op: OP_ACCEPT,     cond: C_NO_IN,      target: S_IDLE};
            5'd1:  w = '{op: OP_NOP,        cond: C_NOT_FRESH,  target: S_EMIT};
            5'd2:  w = '{op: OP_SQRT_EFF,   cond: C_NONE,       target: S_IDLE};
            5'd3:  w = '{op: OP_NOP,        cond: C_SQRT_BUSY,  target: S_WAIT_ROOT};
            5'd4:  w = '{op: OP_SET_XFIRST, cond: C_NONE,       target: S_IDLE};
            5'd5:  w = '{op: OP_SQ_X,       cond: C_NONE,       target: S_IDLE};
            5'd6:  w = '{op: OP_SQRT_REM,   cond: C_NONE,       target: S_IDLE};
            5'd7:  w = '{op: OP_NOP,        cond: C_SQRT_BUSY,  target: S_WAIT_REM};
            5'd8:  w = '{op: OP_SET_YFIRST, cond: C_NONE,       target: S_IDLE};
            5'd9:  w = '{op: OP_SQ_Y,       cond: C_Y_GT_YL,    target: S_NEXT_SLICE};
            5'd10: w = '{op: OP_SQRT_COL,   cond: C_NONE,       target: S_IDLE};
            5'd11: w = '{op: OP_NOP,        cond: C_SQRT_BUSY,  target: S_WAIT_COL};
            5'd12: w = '{op: OP_SET_Z,      cond: C_COL_EMPTY,  target: S_NEXT_COL};
            5'd13: w = '{op: OP_NOP,        cond: C_LOADING,    target: S_EMIT};
            5'd14: w = '{op: OP_CLR_LAST,   cond: C_ALWAYS,     target: S_DELIVER};
            5'd15: w = '{op: OP_INC_Y,      cond: C_ALWAYS,     target: S_TRY};
            5'd16: w = '{op: OP_NOP,        cond: C_X_AT_LIM,   target: S_EXHAUST};
            5'd17: w = '{op: OP_INC_X,      cond: C_ALWAYS,     target: S_SLICE};
            5'd18: w = '{op: OP_SET_LAST,   cond: C_ALWAYS,     target: S_DELIVER};
            5'd19: w = '{op: OP_EMIT,       cond: C_Z_NOT_FITS, target: S_NEXT_COL};
            5'd20: w = '{op: OP_INC_Z,      cond: C_ALWAYS,     target: S_DELIVER};
            5'd21: w = '{op: OP_NOP,        cond: C_OUT_BUSY,   target: S_DELIVER};
            5'd22: w = '{op: OP_DELIVER,    cond: C_ALWAYS,     target: S_IDLE};
            default: w = '{op: OP_NOP, cond: C_ALWAYS, target: S_IDLE};
        endcase
        return w;
    endfunction

endpackage

### rtl/core/fcc_ball_point_enumerator.sv
// Top level of the FCC ball point enumerator: sequencer plus datapath.
// Depends on fcc_pkg, fcc_sequencer, fcc_datapath and fcc_isqrt.
//
// Each input beat asks for one lattice point (x, y, z) with x*x + y*y + z*z no
// larger than the squared radius and x + y + z even, in ascending x, then y, then
// z; restart begins a fresh enumeration, and after the point flagged final the
// next beat starts over. A write to the radius register also begins anew, and is
// taken only while the block waits for an input beat. One input beat is taken at
// a time. The next z in the same column needs no root; moving to a new column
// runs one 14-bit integer square root, one result bit per cycle, through the
// single shared root unit; a new x slice adds a second root, and a fresh start a
// third. Each skipped empty column runs one more root. The result register lets
// the next beat be accepted while the previous point waits to be taken.
module fcc_ball_point_enumerator #(
    parameter int unsigned MAX_RADIUS_SQ = fcc_pkg::MAX_RADIUS_SQ_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic                        i_restart,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [fcc_pkg::COORD_W-1:0] o_px,
    output logic [fcc_pkg::COORD_W-1:0] o_py,
    output logic [fcc_pkg::COORD_W-1:0] o_pz,
    output logic                        o_final_point,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [fcc_pkg::RAD_W-1:0]   i_cfg_radius_sq
);
    import fcc_pkg::*;

    t_op     op;
    t_status status;

    // Both request channels are open only on the waiting step of the program.
    assign o_in_ready  = op == OP_ACCEPT;
    assign o_cfg_ready = op == OP_ACCEPT;

    fcc_sequencer u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (status),
        .o_op     (op)
    );

    fcc_datapath #(
        .MAX_RADIUS_SQ (MAX_RADIUS_SQ)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_op            (op),
        .i_in_valid      (i_in_valid),
        .i_restart       (i_restart),
        .i_out_ready     (i_out_ready),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_radius_sq (i_cfg_radius_sq),
        .o_status        (status),
        .o_out_valid     (o_out_valid),
        .o_px            (o_px),
        .o_py            (o_py),
        .o_pz            (o_pz),
        .o_final_point   (o_final_point)
    );

endmodule

### rtl/core/fcc_isqrt.sv
// Bit-serial integer square root, one result bit per clock cycle.
// Depends on fcc_pkg for the operand and root widths.
module fcc_isqrt (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [fcc_pkg::RAD_W-1:0]  i_value,
    output logic                       o_busy,
    output logic [fcc_pkg::ROOT_W-1:0] o_root
);
    import fcc_pkg::*;

    logic [RAD_W-1:0] r_v;
    logic [RAD_W:0]   r_r;
    logic [RAD_W-1:0] r_bit;
    logic [RAD_W:0]   trial;
    logic             fits;

    // Trial subtraction of the current root estimate plus the bit under test.
    assign trial = r_r + {1'b0, r_bit};
    assign fits  = {1'b0, r_v} >= trial;

    // The bit marker walks down two places a cycle; the root is done when it is empty.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit <= '0;
        end else if (i_start) begin
            r_bit <= RAD_W'(1) << (RAD_W - 2);
        end else begin
            r_bit <= r_bit >> 2;
        end
    end

    // Remainder and root estimate; payload only, so no reset.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_v <= i_value;
            r_r <= '0;
        end else if (r_bit != '0) begin
            if (fits) begin
                r_v <= RAD_W'({1'b0, r_v} - trial);
                r_r <= (r_r >> 1) + {1'b0, r_bit};
            end else begin
                r_r <= r_r >> 1;
            end
        end
    end

    assign o_busy = r_bit != '0;
    assign o_root = r_r[ROOT_W-1:0];

endmodule

### rtl/core/fcc_datapath.sv
// Datapath of the enumerator: cursors, bounds, squarer, root unit and result register.
// Depends on fcc_pkg and fcc_isqrt; driven one operation a cycle by fcc_sequencer.
module fcc_datapath #(
    parameter int unsigned MAX_RADIUS_SQ = fcc_pkg::MAX_RADIUS_SQ_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  fcc_pkg::t_op                i_op,
    input  logic                        i_in_valid,
    input  logic                        i_restart,
    input  logic                        i_out_ready,
    input  logic                        i_cfg_valid,
    input  logic [fcc_pkg::RAD_W-1:0]   i_cfg_radius_sq,
    output fcc_pkg::t_status            o_status,
    output logic                        o_out_valid,
    output logic [fcc_pkg::COORD_W-1:0] o_px,
    output logic [fcc_pkg::COORD_W-1:0] o_py,
    output logic [fcc_pkg::COORD_W-1:0] o_pz,
    output logic                        o_final_point
);
    import fcc_pkg::*;

    localparam logic [RAD_W-1:0] SAT_RADIUS =
        (MAX_RADIUS_SQ > RAD_MAX) ? RAD_W'(RAD_MAX) : RAD_W'(MAX_RADIUS_SQ);

    // Control state.
    logic r_active;
    logic r_out_valid;
    logic [RAD_W-1:0] r_radius;

    // Working registers.
    logic               r_fresh;
    logic               r_loading;
    logic               r_last;
    logic [COORD_W-1:0] r_x;
    logic [COORD_W:0]   r_y;
    logic [COORD_W-1:0] r_z;
    logic [ROOT_W-1:0]  r_xlim;
    logic [ROOT_W-1:0]  r_yl;
    logic [ROOT_W-1:0]  r_zl;
    logic [RAD_W-1:0]   r_rem;
    logic [RAD_W-1:0]   r_sq;
    logic [COORD_W-1:0] r_hx;
    logic [COORD_W-1:0] r_hy;
    logic [COORD_W-1:0] r_hz;

    logic [RAD_W-1:0]        eff_radius;
    logic [RAD_W-1:0]        sqrt_in;
    logic                    sqrt_start;
    logic                    sqrt_busy;
    logic [ROOT_W-1:0]       root;
    logic signed [COORD_W:0] sq_src;
    logic signed [2*COORD_W+1:0] sq_prod;
    logic                    z_par;
    logic [COORD_W:0]        z_next;

    // Squared radius after saturation.
    assign eff_radius = (r_radius > SAT_RADIUS) ? SAT_RADIUS : r_radius;

    // Operand selection for the shared root unit.
    always_comb begin
        sqrt_in    = eff_radius;
        sqrt_start = 1'b0;
        case (i_op)
            OP_SQRT_EFF: begin
                sqrt_in    = eff_radius;
                sqrt_start = 1'b1;
            end
            OP_SQRT_REM: begin
                sqrt_in    = eff_radius - r_sq;
                sqrt_start = 1'b1;
            end
            OP_SQRT_COL: begin
                sqrt_in    = r_rem - r_sq;
                sqrt_start = 1'b1;
            end
            default: begin
                sqrt_in    = eff_radius;
                sqrt_start = 1'b0;
            end
        endcase
    end

    fcc_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sqrt_start),
        .i_value (sqrt_in),
        .o_busy  (sqrt_busy),
        .o_root  (root)
    );

    // Shared squarer for the slice and column coordinates.
    assign sq_src  = (i_op == OP_SQ_X) ? $signed({r_x[COORD_W-1], r_x}) : $signed(r_y);
    assign sq_prod = sq_src * sq_src;

    // Lowest z of the right parity: step up by one when x + y - root is odd.
    assign z_par  = r_x[0] ^ r_y[0] ^ root[0];
    assign z_next = {r_z[COORD_W-1], r_z} + (COORD_W+1)'(2);

    // Flags for the sequencer's jumps.
    always_comb begin
        o_status.in_valid  = i_in_valid;
        o_status.fresh     = r_fresh;
        o_status.sqrt_busy = sqrt_busy;
        o_status.y_gt_yl   = $signed(r_y) > $signed({2'b00, r_yl});
        o_status.col_empty = (root == '0) && z_par;
        o_status.loading   = r_loading;
        o_status.x_at_lim  = $signed(r_x) >= $signed({1'b0, r_xlim});
        o_status.z_fits    = $signed(z_next) <= $signed({2'b00, r_zl});
        o_status.out_busy  = r_out_valid && !i_out_ready;
    end

    // Register, enumeration flag and result valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius    <= RAD_W'(RADIUS_RST);
            r_active    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && i_op == OP_ACCEPT) begin
                r_radius <= i_cfg_radius_sq;
                r_active <= 1'b0;
            end else if (i_op == OP_DELIVER) begin
                r_active <= !r_last;
            end
            if (i_op == OP_DELIVER) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Cursor and bound updates, one operation per cycle.
    always_ff @(posedge i_clk) begin
        case (i_op)
            OP_ACCEPT: begin
                r_fresh <= i_restart || !r_active || i_cfg_valid;
            end
            OP_SQRT_EFF: begin
                r_loading <= 1'b1;
            end
            OP_SET_XFIRST: begin
                r_xlim <= root;
                r_x    <= COORD_W'(0) - {1'b0, root};
            end
            OP_SQ_X, OP_SQ_Y: begin
                r_sq <= sq_prod[RAD_W-1:0];
            end
            OP_SQRT_REM: begin
                r_rem <= eff_radius - r_sq;
            end
            OP_SET_YFIRST: begin
                r_yl <= root;
                r_y  <= (COORD_W+1)'(0) - {2'b00, root};
            end
            OP_SET_Z: begin
                r_zl <= root;
                r_z  <= COORD_W'(0) - {1'b0, root} + {{(COORD_W-1){1'b0}}, z_par};
            end
            OP_CLR_LAST: begin
                r_last <= 1'b0;
            end
            OP_INC_Y: begin
                r_y <= r_y + (COORD_W+1)'(1);
            end
            OP_INC_X: begin
                r_x <= r_x + COORD_W'(1);
            end
            OP_SET_LAST: begin
                r_last <= 1'b1;
            end
            OP_EMIT: begin
                r_hx      <= r_x;
                r_hy      <= r_y[COORD_W-1:0];
                r_hz      <= r_z;
                r_loading <= 1'b0;
            end
            OP_INC_Z: begin
                r_z    <= z_next[COORD_W-1:0];
                r_last <= 1'b0;
            end
            OP_DELIVER: begin
                o_px          <= r_hx;
                o_py          <= r_hy;
                o_pz          <= r_hz;
                o_final_point <= r_last;
            end
            default: begin
            end
        endcase
    end

    assign o_out_valid = r_out_valid;

endmodule

### rtl/core/fcc_sequencer.sv
// Microcode sequencer: step counter, control store lookup and conditional jumps.
// Depends on fcc_pkg for the control words and the datapath flags.
module fcc_sequencer (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  fcc_pkg::t_status i_status,
    output fcc_pkg::t_op     o_op
);
    import fcc_pkg::*;

    t_pc    r_pc;
    t_pc    n_pc;
    t_uword word;
    logic   take;

    assign word = ucode(r_pc);
    assign o_op = word.op;

    // Evaluate the jump condition of the current word.
    always_comb begin
        case (word.cond)
            C_NONE:       take = 1'b0;
            C_ALWAYS:     take = 1'b1;
            C_NO_IN:      take = !i_status.in_valid;
            C_NOT_FRESH:  take = !i_status.fresh;
            C_SQRT_BUSY:  take = i_status.sqrt_busy;
            C_Y_GT_YL:    take = i_status.y_gt_yl;
            C_COL_EMPTY:  take = i_status.col_empty;
            C_LOADING:    take = i_status.loading;
            C_X_AT_LIM:   take = i_status.x_at_lim;
            C_Z_NOT_FITS: take = !i_status.z_fits;
            C_OUT_BUSY:   take = i_status.out_busy;
            default:      take = 1'b0;
        endcase
        n_pc = take ? word.target : r_pc + t_pc'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= S_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

endmodule

### rtl/core/fcc_checker.sv
// Port-level checks for the FCC ball point enumerator, attached by a bind.
// Depends on fcc_pkg for the field widths.
module fcc_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        o_out_valid,
    input logic                        i_out_ready,
    input logic [fcc_pkg::COORD_W-1:0] o_px,
    input logic [fcc_pkg::COORD_W-1:0] o_py,
    input logic [fcc_pkg::COORD_W-1:0] o_pz,
    input logic                        o_final_point
);
    import fcc_pkg::*;

    logic [2*COORD_W+1:0] sum_sq;
    logic signed [COORD_W-1:0] sx;
    logic signed [COORD_W-1:0] sy;
    logic signed [COORD_W-1:0] sz;

    assign sx = $signed(o_px);
    assign sy = $signed(o_py);
    assign sz = $signed(o_pz);

    // Squared distance of the shown point from the origin.
    assign sum_sq = (2*COORD_W+2)'(sx * sx) + (2*COORD_W+2)'(sy * sy)
                  + (2*COORD_W+2)'(sz * sz);

    // A stalled result beat holds its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_px) && $stable(o_py)
            && $stable(o_pz) && $stable(o_final_point))
        else $error("result beat changed while stalled");

    // Every point lies on the face-centred cubic lattice.
    a_parity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_px[0] ^ o_py[0] ^ o_pz[0]) == 1'b0)
        else $error("point has odd coordinate sum");

    // Every point lies inside the largest ball the register can describe.
    a_in_ball: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> sum_sq <= (2*COORD_W+2)'(RAD_MAX))
        else $error("point outside the ball");

    // The last point of an enumeration has a non-negative x.
    a_final_x: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_final_point |-> sx >= 0)
        else $error("final point with negative x");

endmodule

bind fcc_ball_point_enumerator fcc_checker u_fcc_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_out_valid     (o_out_valid),
    .i_out_ready     (i_out_ready),
    .o_px            (o_px),
    .o_py            (o_py),
    .o_pz            (o_pz),
    .o_final_point   (o_final_point)
);

### tb/fcc_point_checker.sv
// Scoreboard for the FCC ball point enumerator: watches the request, point and radius channels.
// Predicts each lattice point and compares it with the returned beat.
// Depends on fcc_pkg for the field widths and the reset radius.
`timescale 1ns / 1ps

module fcc_point_checker #(
    parameter int unsigned MAX_RADIUS_SQ = fcc_pkg::MAX_RADIUS_SQ_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic                        i_in_ready,
    input  logic                        i_restart,
    input  logic                        i_out_valid,
    input  logic                        i_out_ready,
    input  logic [fcc_pkg::COORD_W-1:0] i_px,
    input  logic [fcc_pkg::COORD_W-1:0] i_py,
    input  logic [fcc_pkg::COORD_W-1:0] i_pz,
    input  logic                        i_final_point,
    input  logic                        i_cfg_valid,
    input  logic                        i_cfg_ready,
    input  logic [fcc_pkg::RAD_W-1:0]   i_cfg_radius_sq,
    output int                          o_fail_count,
    output int                          o_pending,
    output int                          o_points_seen,
    output int                          o_finals_seen
);

    localparam int unsigned CW = fcc_pkg::COORD_W;

    typedef struct packed {
        logic [CW-1:0] x;
        logic [CW-1:0] y;
        logic [CW-1:0] z;
        logic          last;
    } t_lattice_point;

    // Points owed to the requests accepted so far, oldest first.
    t_lattice_point due_points[$];

    // Own copy of the enumeration state and of the radius register.
    int unsigned radius_sq   = fcc_pkg::RADIUS_RST;
    int          cur_x       = 0;
    int          cur_y       = 0;
    int          cur_z       = 0;
    int          y_half      = 0;
    int          z_half      = 0;
    int          slice_rem   = 0;
    bit          walking     = 1'b0;
    int          fails       = 0;
    int          points_seen = 0;
    int          finals_seen = 0;

    initial begin
        o_fail_count  = 0;
        o_pending     = 0;
        o_points_seen = 0;
        o_finals_seen = 0;
    end

    // Floor of the square root, found by counting upwards.
    function automatic int root_floor(input int v);
        int r;
        r = 0;
        while ((r + 1) * (r + 1) <= v) r++;
        return r;
    endfunction

    function automatic int eff_radius();
        return (radius_sq > MAX_RADIUS_SQ) ? int'(MAX_RADIUS_SQ) : int'(radius_sq);
    endfunction

    // Moves to slice x and works out the y half-extent of that slice.
    function automatic void open_slice(input int x);
        cur_x     = x;
        slice_rem = eff_radius() - x * x;
        y_half    = root_floor(slice_rem);
    endfunction

    // Column (cur_x, y) holds a point when its lowest z of even total parity still fits.
    function automatic bit open_column(input int y);
        int zl;
        int z0;
        zl = root_floor(slice_rem - y * y);
        z0 = -zl;
        if (((cur_x + y + z0) & 1) != 0) z0++;
        if (z0 > zl) return 1'b0;
        cur_y  = y;
        cur_z  = z0;
        z_half = zl;
        return 1'b1;
    endfunction

    // Walks columns from y onwards, slice after slice; 0 once the ball is used up.
    function automatic bit find_column(input int y);
        int x_edge;
        x_edge = root_floor(eff_radius());
        forever begin
            while (y <= y_half) begin
                if (open_column(y)) return 1'b1;
                y++;
            end
            if (cur_x >= x_edge) return 1'b0;
            open_slice(cur_x + 1);
            y = -y_half;
        end
    endfunction

    // Point owed to one request, advancing the walk past it.
    function automatic t_lattice_point next_point(input logic fresh);
        t_lattice_point p;
        bit             done;
        if (fresh || !walking) begin
            open_slice(-root_floor(eff_radius()));
            void'(find_column(-y_half));
        end
        p.x = cur_x[CW-1:0];
        p.y = cur_y[CW-1:0];
        p.z = cur_z[CW-1:0];
        if (cur_z + 2 <= z_half) begin
            cur_z += 2;
            done = 1'b0;
        end else begin
            done = !find_column(cur_y + 1);
        end
        walking = !done;
        p.last  = done;
        return p;
    endfunction

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got) begin
            fails++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endfunction

    // All beats are sampled at the rising edge, before the edge's own updates land.
    always @(posedge i_clk) begin
        t_lattice_point want;
        if (!i_rst_n) begin
            radius_sq = fcc_pkg::RADIUS_RST;
            walking   = 1'b0;
            due_points.delete();
        end else begin
            // A returned beat always answers an earlier request, so it is compared first.
            if (i_out_valid && i_out_ready) begin
                points_seen++;
                if (i_final_point) finals_seen++;
                if (due_points.size() == 0) begin
                    fails++;
                    $display("%0t: point beat with nothing outstanding, x %0d y %0d z %0d final %0b",
                             $time, $signed(i_px), $signed(i_py), $signed(i_pz), i_final_point);
                end else begin
                    want = due_points.pop_front();
                    check_field("px", int'($signed(want.x)), int'($signed(i_px)));
                    check_field("py", int'($signed(want.y)), int'($signed(i_py)));
                    check_field("pz", int'($signed(want.z)), int'($signed(i_pz)));
                    check_field("final_point", int'(want.last), int'(i_final_point));
                end
            end
            // A radius write begins the enumeration anew.
            if (i_cfg_valid && i_cfg_ready) begin
                radius_sq = 32'(i_cfg_radius_sq);
                walking   = 1'b0;
            end
            if (i_in_valid && i_in_ready) begin
                due_points.insert(due_points.size(), next_point(i_restart));
            end
        end
        o_fail_count  <= fails;
        o_pending     <= due_points.size();
        o_points_seen <= points_seen;
        o_finals_seen <= finals_seen;
    end

endmodule

### tb/tb.sv
// Top of the FCC ball point enumerator testbench: clock, reset, stimulus and verdict.
// Depends on fcc_pkg, the enumerator RTL and fcc_point_checker.
`timescale 1ns / 1ps

module tb;

    import fcc_pkg::*;

    localparam int RUN_LIMIT    = 1_000_000;
    localparam int RANDOM_ITEMS = 1450;
    localparam int QUIET_TAIL   = 150;
    localparam int SETTLE       = 60;

    logic               clk           = 1'b0;
    logic               rst_n         = 1'b0;
    logic               req_valid     = 1'b0;
    logic               req_ready;
    logic               req_restart   = 1'b0;
    logic               pt_valid;
    logic               pt_ready      = 1'b0;
    logic [COORD_W-1:0] pt_x;
    logic [COORD_W-1:0] pt_y;
    logic [COORD_W-1:0] pt_z;
    logic               pt_final;
    logic               cfg_valid     = 1'b0;
    logic               cfg_ready;
    logic [RAD_W-1:0]   cfg_radius_sq = '0;

    int fails;
    int pending;
    int points_seen;
    int finals_seen;
    int cycle_count    = 0;
    int sent           = 0;
    int restarts       = 0;
    int radius_writes  = 0;
    int stall_left     = 0;
    bit quiet_tail     = 1'b0;

    always #5 clk = ~clk;

    fcc_ball_point_enumerator dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (req_valid),
        .o_in_ready      (req_ready),
        .i_restart       (req_restart),
        .o_out_valid     (pt_valid),
        .i_out_ready     (pt_ready),
        .o_px            (pt_x),
        .o_py            (pt_y),
        .o_pz            (pt_z),
        .o_final_point   (pt_final),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_radius_sq (cfg_radius_sq)
    );

    fcc_point_checker u_point_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (req_valid),
        .i_in_ready      (req_ready),
        .i_restart       (req_restart),
        .i_out_valid     (pt_valid),
        .i_out_ready     (pt_ready),
        .i_px            (pt_x),
        .i_py            (pt_y),
        .i_pz            (pt_z),
        .i_final_point   (pt_final),
        .i_cfg_valid     (cfg_valid),
        .i_cfg_ready     (cfg_ready),
        .i_cfg_radius_sq (cfg_radius_sq),
        .o_fail_count    (fails),
        .o_pending       (pending),
        .o_points_seen   (points_seen),
        .o_finals_seen   (finals_seen)
    );

    // Guard against a hang anywhere in the run.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= RUN_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // Point receiver: stalls at random in bursts, never in the tail.
    always @(posedge clk) begin
        if (quiet_tail) begin
            pt_ready <= 1'b1;
        end else if (stall_left != 0) begin
            pt_ready   <= 1'b0;
            stall_left <= stall_left - 1;
        end else if ($urandom_range(0, 5) == 0) begin
            pt_ready   <= 1'b0;
            stall_left <= $urandom_range(0, 9);
        end else begin
            pt_ready <= 1'b1;
        end
    end

    // One request beat, sometimes after a gap; valid stays high between back-to-back beats.
    task automatic send_request(input logic fresh);
        if (!quiet_tail && $urandom_range(0, 3) == 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        req_valid   <= 1'b1;
        req_restart <= fresh;
        @(posedge clk);
        while (!req_ready) @(posedge clk);
        sent++;
        if (fresh) restarts++;
    endtask

    // Holds the requests back until every owed point has come back.
    task automatic drain_points();
        req_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    // Radius writes only go in once the block has nothing left in flight.
    task automatic write_radius(input logic [RAD_W-1:0] r);
        drain_points();
        cfg_valid     <= 1'b1;
        cfg_radius_sq <= r;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        radius_writes++;
    endtask

    initial begin
        int                  total;
        int                  run_len;
        logic [RAD_W-1:0]    r;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Reset radius: the origin and its twelve neighbours, then the wrap and a restart.
        repeat (15) send_request(1'b0);
        send_request(1'b1);
        send_request(1'b0);

        // Zero radius: only the origin, flagged final every time.
        write_radius('0);
        send_request(1'b0);
        send_request(1'b1);
        send_request(1'b0);

        // Largest radius: the walk starts at x = -127.
        write_radius(RAD_MAX[RAD_W-1:0]);
        send_request(1'b0);
        send_request(1'b0);
        send_request(1'b1);
        send_request(1'b0);

        // Random phases, mostly small balls so enumerations wrap often.
        total = sent + RANDOM_ITEMS;
        while (sent < total) begin
            case ($urandom_range(0, 15))
                0:       r = RAD_MAX[RAD_W-1:0];
                1:       r = '0;
                2, 3:    r = RAD_W'($urandom_range(81, RAD_MAX));
                4:       r = 'x;
                default: r = RAD_W'($urandom_range(1, 80));
            endcase
            // Now and then keep the radius and only pause until the block is empty.
            if ($isunknown(r)) drain_points();
            else write_radius(r);
            run_len = $urandom_range(10, 120);
            repeat (run_len) begin
                if (sent >= total - QUIET_TAIL) quiet_tail = 1'b1;
                send_request($urandom_range(0, 19) == 0);
            end
        end

        drain_points();
        repeat (SETTLE) @(posedge clk);
        $display("Covered %0d point requests, %0d with restart, over %0d radius writes.",
                 sent, restarts, radius_writes);
        $display("Compared %0d returned points, %0d of which closed an enumeration.",
                 points_seen, finals_seen);
        if (fails == 0 && pending == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
